### design/cotangent_edge_weight_assert.svh
// Assertion macros for the cotangent edge weight block.
// Needs clk and rst_n in the scope where the macros are used.
`ifndef COTANGENT_EDGE_WEIGHT_ASSERT_SVH
`define COTANGENT_EDGE_WEIGHT_ASSERT_SVH

// Same-cycle implication, off while reset is held.
`define CEW_ASSERT_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is held.
`define CEW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/cew_pkg.sv
// Shared widths, register indexes and reset values for the cotangent edge weight block.
// No dependencies.
package cew_pkg;

  localparam int FIELD_W    = 32;   // width of every coordinate field and configuration register
  localparam int NUM_COORDS = 9;
  localparam int NUM_DIFFS  = 6;
  localparam int DIFF_W     = 33;   // coordinate difference, signed
  localparam int SV_W       = 31;   // shrunk difference, signed, magnitude below 2^30
  localparam int MUL_W      = 33;   // multiplier operand, signed
  localparam int PROD_W     = 2 * MUL_W;
  localparam int ACC_W      = 63;   // cross component or dot product, signed
  localparam int CMAG_W     = 61;   // magnitude of a cross component
  localparam int HALF_W     = 32;   // low half used to split a square
  localparam int SQ_W       = 124;  // sum of squared cross components
  localparam int ROOT_W     = 62;   // square root, also the norm
  localparam int REM_W      = 66;   // shared remainder
  localparam int Q_W        = 47;   // quotient magnitude in Q31.16
  localparam int FRAC_W     = 16;
  localparam int SUM_W      = 48;
  localparam int CNT_W      = 6;

  localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(18);
  localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(ROOT_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(Q_W - 1);

  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] REG_CROSS_NORM_FLOOR = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_WEIGHT_FLOOR     = 1'b1;

  localparam logic [FIELD_W-1:0] CROSS_NORM_FLOOR_RST = 32'd4295;
  localparam logic [FIELD_W-1:0] WEIGHT_FLOOR_RST     = 32'd7;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [SV_W-1:0]   sv_t;
  typedef logic signed [MUL_W-1:0]  mul_op_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

endpackage

### design/cotangent_edge_weight.sv
// Cotangent weight of one mesh edge, one adjacent face per input beat.
// Depends on cew_pkg and on the assertion macros in cotangent_edge_weight_assert.svh.
//
// Each input beat carries the edge endpoints, the vertex opposite the edge in one
// face, a face-present flag (tuser) and a last-face flag (tlast). For a present face
// the block forms a = start - opp and b = end - opp, scales them down by the smallest
// shift 0..3 that keeps every component below 2^30, and adds dot(a,b)/|a x b| in
// Q31.16 to a saturating 48-bit sum; a face whose cross norm is at or below
// cross_norm_floor adds nothing. On the last beat of an edge one result beat leaves:
// max(sum/2, weight_floor), saturated to 32 bits with a flag, and the sum clears.
// All work runs on one 33x33 multiplier and one 66-bit subtractor under a sequencer,
// one item at a time. A present face goes through capture, shift select, 19 multiply
// slots (9 products for cross and dot, 9 partial squares), 62 square-root steps, the
// floor check, 47 divide steps, accumulate and finish before the next beat is taken.
// The root and the divide both step one bit per cycle through the shared subtractor.
// A face skipped by the floor goes from the check to finish, one whose cotangent
// saturates skips the divide, a boundary beat goes from capture to finish. A result
// waits in an output register, so the next beat is taken while it is still held.
`include "cotangent_edge_weight_assert.svh"

module cotangent_edge_weight
  import cew_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input beats
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z, opp_x, opp_y, opp_z (32 each)
  input  logic [NUM_COORDS*FIELD_W-1:0] in_tdata,
  // has_face
  input  logic [0:0]                    in_tuser,
  input  logic                          in_tlast,   // last_face
  // result beats
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // edge_weight
  output logic [FIELD_W-1:0]            out_tdata,
  // saturated
  output logic [0:0]                    out_tuser,
  // configuration writes
  input  logic                          cfg_we,
  input  logic [CFG_ADDR_W-1:0]         cfg_addr,
  input  logic [FIELD_W-1:0]            cfg_wdata
);

  // Only the low bits of each coordinate count, sign extended.
  localparam int CW_EFF = (COORD_WIDTH < FIELD_W) ? COORD_WIDTH : FIELD_W;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SHIFT  = 3'd1;
  localparam logic [2:0] ST_MUL    = 3'd2;
  localparam logic [2:0] ST_SQRT   = 3'd3;
  localparam logic [2:0] ST_CHECK  = 3'd4;
  localparam logic [2:0] ST_DIV    = 3'd5;
  localparam logic [2:0] ST_ACCUM  = 3'd6;
  localparam logic [2:0] ST_FINISH = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [FIELD_W-1:0] cross_floor_r;
  logic [FIELD_W-1:0] weight_floor_r;

  logic signed [SUM_W-1:0] cot_sum_r;

  logic               out_valid_r;
  logic [FIELD_W-1:0] out_weight_r;
  logic               out_sat_r;

  // datapath registers
  diff_t              d_r  [NUM_DIFFS];
  sv_t                sv_r [NUM_DIFFS];
  logic [1:0]         s_r;
  logic               last_r;
  logic signed [PROD_W-1:0] prod_r;
  acc_t               cx_r, cy_r, cz_r, dot_r;
  logic [SQ_W-1:0]    sq_r;
  logic [ROOT_W-1:0]  root_r;
  logic [REM_W-1:0]   rem_r;
  logic [Q_W-1:0]     dq_r;
  logic               cot_neg_r;

  //--------------------------------------------------------------------------
  // Capture: coordinates to differences against the opposite vertex
  //--------------------------------------------------------------------------
  diff_t in_coord [NUM_COORDS];
  diff_t in_diff  [NUM_DIFFS];

  for (genvar g = 0; g < NUM_COORDS; g++) begin : g_coord
    assign in_coord[g] = DIFF_W'($signed(in_tdata[g*FIELD_W +: CW_EFF]));
  end
  for (genvar g = 0; g < NUM_DIFFS; g++) begin : g_diff
    assign in_diff[g] = in_coord[g] - in_coord[NUM_DIFFS + (g % 3)];
  end

  logic in_acc;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  //--------------------------------------------------------------------------
  // Shift select: smallest s that brings every magnitude below 2^30
  //--------------------------------------------------------------------------
  logic [DIFF_W-1:0] d_mag [NUM_DIFFS];
  logic [DIFF_W-1:0] mag_or;
  logic [1:0]        shift_sel;
  sv_t               sv_nxt [NUM_DIFFS];

  for (genvar g = 0; g < NUM_DIFFS; g++) begin : g_mag
    logic [DIFF_W-1:0] sh_mag;
    assign d_mag[g]  = d_r[g][DIFF_W-1] ? DIFF_W'(-d_r[g]) : DIFF_W'(d_r[g]);
    assign sh_mag    = d_mag[g] >> shift_sel;
    assign sv_nxt[g] = d_r[g][DIFF_W-1] ? -$signed({1'b0, sh_mag[SV_W-2:0]})
                                        :  $signed({1'b0, sh_mag[SV_W-2:0]});
  end

  always_comb begin
    mag_or = '0;
    for (int i = 0; i < NUM_DIFFS; i++) begin
      mag_or = mag_or | d_mag[i];
    end
    if (mag_or[DIFF_W-1:SV_W-1] == '0) begin
      shift_sel = 2'd0;
    end else if (mag_or[DIFF_W-1:SV_W] == '0) begin
      shift_sel = 2'd1;
    end else if (mag_or[DIFF_W-1] == 1'b0) begin
      shift_sel = 2'd2;
    end else begin
      shift_sel = 2'd3;
    end
  end

  //--------------------------------------------------------------------------
  // Shared multiplier schedule. Slot t issues product t and folds in product
  // t-1 from the product register. Slots 0..8 build cx, cy, cz and dot; slots
  // 9..17 square each cross magnitude split as hi*2^32 + lo.
  //--------------------------------------------------------------------------
  logic [CMAG_W-1:0] cmag_x, cmag_y, cmag_z;
  mul_op_t           op_a, op_b;

  assign cmag_x = cx_r[ACC_W-1] ? CMAG_W'(-cx_r) : CMAG_W'(cx_r);
  assign cmag_y = cy_r[ACC_W-1] ? CMAG_W'(-cy_r) : CMAG_W'(cy_r);
  assign cmag_z = cz_r[ACC_W-1] ? CMAG_W'(-cz_r) : CMAG_W'(cz_r);

  function automatic mul_op_t lo_op(input logic [CMAG_W-1:0] m);
    lo_op = $signed({1'b0, m[HALF_W-1:0]});
  endfunction

  function automatic mul_op_t hi_op(input logic [CMAG_W-1:0] m);
    hi_op = $signed({{(MUL_W-CMAG_W+HALF_W){1'b0}}, m[CMAG_W-1:HALF_W]});
  endfunction

  // sv_r: 0 ax, 1 ay, 2 az, 3 bx, 4 by, 5 bz
  always_comb begin
    case (cnt_r)
      6'd0:    begin op_a = MUL_W'(sv_r[1]); op_b = MUL_W'(sv_r[5]); end  // ay*bz
      6'd1:    begin op_a = MUL_W'(sv_r[2]); op_b = MUL_W'(sv_r[4]); end  // az*by
      6'd2:    begin op_a = MUL_W'(sv_r[2]); op_b = MUL_W'(sv_r[3]); end  // az*bx
      6'd3:    begin op_a = MUL_W'(sv_r[0]); op_b = MUL_W'(sv_r[5]); end  // ax*bz
      6'd4:    begin op_a = MUL_W'(sv_r[0]); op_b = MUL_W'(sv_r[4]); end  // ax*by
      6'd5:    begin op_a = MUL_W'(sv_r[1]); op_b = MUL_W'(sv_r[3]); end  // ay*bx
      6'd6:    begin op_a = MUL_W'(sv_r[0]); op_b = MUL_W'(sv_r[3]); end
      6'd7:    begin op_a = MUL_W'(sv_r[1]); op_b = MUL_W'(sv_r[4]); end
      6'd8:    begin op_a = MUL_W'(sv_r[2]); op_b = MUL_W'(sv_r[5]); end
      6'd9:    begin op_a = lo_op(cmag_x); op_b = lo_op(cmag_x); end
      6'd10:   begin op_a = hi_op(cmag_x); op_b = lo_op(cmag_x); end
      6'd11:   begin op_a = hi_op(cmag_x); op_b = hi_op(cmag_x); end
      6'd12:   begin op_a = lo_op(cmag_y); op_b = lo_op(cmag_y); end
      6'd13:   begin op_a = hi_op(cmag_y); op_b = lo_op(cmag_y); end
      6'd14:   begin op_a = hi_op(cmag_y); op_b = hi_op(cmag_y); end
      6'd15:   begin op_a = lo_op(cmag_z); op_b = lo_op(cmag_z); end
      6'd16:   begin op_a = hi_op(cmag_z); op_b = lo_op(cmag_z); end
      6'd17:   begin op_a = hi_op(cmag_z); op_b = hi_op(cmag_z); end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  acc_t            prod_s;
  logic [SQ_W-1:0] prod_u;
  logic [SQ_W-1:0] sq_addend;

  assign prod_s = $signed(prod_r[ACC_W-1:0]);
  assign prod_u = SQ_W'(prod_r[2*HALF_W-1:0]);

  // Weight of each partial square: lo*lo, 2*hi*lo, hi*hi.
  always_comb begin
    case (cnt_r)
      6'd10, 6'd13, 6'd16: sq_addend = prod_u;
      6'd11, 6'd14, 6'd17: sq_addend = prod_u << (HALF_W + 1);
      6'd12, 6'd15, 6'd18: sq_addend = prod_u << (2 * HALF_W);
      default:             sq_addend = '0;
    endcase
  end

  //--------------------------------------------------------------------------
  // Shared subtractor: root step (remainder against 4*root+1) or divide step
  // (remainder against the norm, which stays in root_r)
  //--------------------------------------------------------------------------
  logic [REM_W-1:0] sub_a, sub_b;
  logic [REM_W:0]   sub_diff;
  logic             sub_ge;

  always_comb begin
    if (state_r == ST_SQRT) begin
      sub_a = {rem_r[REM_W-3:0], sq_r[SQ_W-1:SQ_W-2]};
      sub_b = REM_W'({root_r, 2'b01});
    end else begin
      sub_a = REM_W'({rem_r[REM_W-4:0], dq_r[Q_W-1]});
      sub_b = REM_W'(root_r);
    end
  end

  assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge   = !sub_diff[REM_W];

  //--------------------------------------------------------------------------
  // Floor check and divide setup
  //--------------------------------------------------------------------------
  logic [FIELD_W-1:0]     norm_lim;
  logic [ROOT_W-1:0]      num;
  logic                   face_skip;
  logic                   cot_sat;

  assign norm_lim  = cross_floor_r >> {s_r, 1'b0};
  assign num       = dot_r[ACC_W-1] ? ROOT_W'(-dot_r) : ROOT_W'(dot_r);
  assign face_skip = root_r <= ROOT_W'(norm_lim);
  assign cot_sat   = ROOT_W'(num[ROOT_W-1:SV_W]) >= root_r;

  // Accumulate the signed cotangent, clamp to the 48-bit range.
  logic signed [SUM_W:0]   sum_wide;
  logic signed [SUM_W-1:0] sum_sat;

  assign sum_wide = cot_neg_r ? (SUM_W+1)'(cot_sum_r) - $signed({2'b00, dq_r})
                              : (SUM_W+1)'(cot_sum_r) + $signed({2'b00, dq_r});
  always_comb begin
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end
  end

  //--------------------------------------------------------------------------
  // Result: half the sum, clamped below by weight_floor, saturated above
  //--------------------------------------------------------------------------
  logic [SUM_W-2:0]   half_sum;
  logic [FIELD_W-1:0] weight_res;
  logic               sat_res;
  logic               out_load;

  assign half_sum = cot_sum_r[SUM_W-1:1];

  always_comb begin
    sat_res = 1'b0;
    if (cot_sum_r[SUM_W-1] || cot_sum_r == '0) begin
      weight_res = weight_floor_r;
    end else if (half_sum[SUM_W-2:FIELD_W] != '0) begin
      weight_res = '1;
      sat_res    = 1'b1;
    end else if (half_sum[FIELD_W-1:0] < weight_floor_r) begin
      weight_res = weight_floor_r;
    end else begin
      weight_res = half_sum[FIELD_W-1:0];
    end
  end

  // Load the result only when the output register is free or draining.
  assign out_load = (state_r == ST_FINISH) && last_r && (!out_valid_r || out_tready);

  //--------------------------------------------------------------------------
  // Sequencer
  //--------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = in_tuser[0] ? ST_SHIFT : ST_FINISH;
        end
      end
      ST_SHIFT: begin
        state_nxt = ST_MUL;
        cnt_nxt   = '0;
      end
      ST_MUL: begin
        if (cnt_r == MUL_LAST) begin
          state_nxt = ST_SQRT;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_SQRT: begin
        if (cnt_r == SQRT_LAST) begin
          state_nxt = ST_CHECK;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_CHECK: begin
        cnt_nxt = '0;
        if (face_skip) begin
          state_nxt = ST_FINISH;
        end else if (cot_sat) begin
          state_nxt = ST_ACCUM;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_r == DIV_LAST) begin
          state_nxt = ST_ACCUM;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_ACCUM: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        // Hold while a result is due and the output register is still full.
        if (!last_r || out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  //--------------------------------------------------------------------------
  // Control registers
  //--------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      cnt_r          <= '0;
      out_valid_r    <= 1'b0;
      cot_sum_r      <= '0;
      cross_floor_r  <= CROSS_NORM_FLOOR_RST;
      weight_floor_r <= WEIGHT_FLOOR_RST;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      if (out_load) begin
        cot_sum_r <= '0;
      end else if (state_r == ST_ACCUM) begin
        cot_sum_r <= sum_sat;
      end

      if (cfg_we) begin
        case (cfg_addr)
          REG_CROSS_NORM_FLOOR: cross_floor_r  <= cfg_wdata;
          REG_WEIGHT_FLOOR:     weight_floor_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  //--------------------------------------------------------------------------
  // Datapath registers
  //--------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_weight_r <= weight_res;
      out_sat_r    <= sat_res;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          for (int i = 0; i < NUM_DIFFS; i++) begin
            d_r[i] <= in_diff[i];
          end
          last_r <= in_tlast;
        end
      end
      ST_SHIFT: begin
        for (int i = 0; i < NUM_DIFFS; i++) begin
          sv_r[i] <= sv_nxt[i];
        end
        s_r  <= shift_sel;
        sq_r <= '0;
      end
      ST_MUL: begin
        prod_r <= op_a * op_b;
        case (cnt_r)
          6'd1:    cx_r  <= prod_s;
          6'd2:    cx_r  <= cx_r - prod_s;
          6'd3:    cy_r  <= prod_s;
          6'd4:    cy_r  <= cy_r - prod_s;
          6'd5:    cz_r  <= prod_s;
          6'd6:    cz_r  <= cz_r - prod_s;
          6'd7:    dot_r <= prod_s;
          6'd8:    dot_r <= dot_r + prod_s;
          6'd9:    dot_r <= dot_r + prod_s;
          default: sq_r  <= sq_r + sq_addend;
        endcase
        if (cnt_r == MUL_LAST) begin
          rem_r  <= '0;
          root_r <= '0;
        end
      end
      ST_SQRT: begin
        rem_r  <= sub_ge ? sub_diff[REM_W-1:0] : sub_a;
        root_r <= {root_r[ROOT_W-2:0], sub_ge};
        sq_r   <= sq_r << 2;
      end
      ST_CHECK: begin
        cot_neg_r <= dot_r[ACC_W-1];
        rem_r     <= REM_W'(num[ROOT_W-1:SV_W]);
        // Saturated cotangent magnitude is 2^47 - 1.
        dq_r      <= cot_sat ? '1 : {num[SV_W-1:0], {FRAC_W{1'b0}}};
      end
      ST_DIV: begin
        rem_r <= sub_ge ? sub_diff[REM_W-1:0] : sub_a;
        dq_r  <= {dq_r[Q_W-2:0], sub_ge};
      end
      default: ;
    endcase
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_weight_r;
  assign out_tuser[0] = out_sat_r;

  //--------------------------------------------------------------------------
  // Assertions
  //--------------------------------------------------------------------------
  `CEW_ASSERT_HOLDS(a_out_from_finish, $rose(out_valid_r), $past(state_r) == ST_FINISH && $past(last_r), "result beat raised outside a last-face finish")
  `CEW_ASSERT_NEXT(a_sum_cleared, out_load, cot_sum_r == '0, "cot sum not cleared after a result")
  `CEW_ASSERT_HOLDS(a_sqrt_rem_bound, state_r == ST_SQRT, rem_r <= (REM_W'(root_r) << 1), "root remainder above twice the partial root")
  `CEW_ASSERT_HOLDS(a_div_rem_bound, state_r == ST_DIV, rem_r < REM_W'(root_r), "divide remainder not below the norm")

endmodule
